/* rtl/mrpf_pkg.sv */
`default_nettype none

package mrpf_pkg;

    localparam int MAX_POINTS_DEFAULT = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  FUNC_WRITE_MULTI = 8'h10;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Register indexes on the configuration port (paddr[3:2]).
    localparam logic [1:0] REG_SLAVE_ADDRESS    = 2'd0;
    localparam logic [1:0] REG_START_REGISTER   = 2'd1;
    localparam logic [1:0] REG_POINTS_PER_FRAME = 2'd2;

    localparam logic [7:0]  SLAVE_ADDRESS_RESET    = 8'd1;
    localparam logic [15:0] START_REGISTER_RESET   = 16'd8;
    localparam logic [2:0]  POINTS_PER_FRAME_RESET = 3'd1;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] rot_angle;
        logic signed [7:0]  move_speed;
        logic               valve_on;
    } point_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } frame_t;

    // One classified point as it waits between front and back.
    typedef struct packed {
        logic [15:0] word_x;
        logic [15:0] word_y;
        logic [15:0] word_z;
        logic [15:0] word_a;
        logic [7:0]  speed;
        logic        valve;
        logic        first;
        logic        last;
        logic [7:0]  slave;
        logic [15:0] start_reg;
        logic [7:0]  reg_count;
        logic [7:0]  byte_count;
    } entry_t;

    function automatic logic [15:0] times_ten(input logic [15:0] raw);
        times_ten = (raw << 3) + (raw << 1);
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        crc16_byte = crc;
    endfunction

endpackage

`default_nettype wire

/* rtl/modbus_rtu_point_framer_core.sv */
// The first byte of a point reaches out_data through a queue slot and then the output register.
// A point takes ten bytes, seventeen for a point that opens a frame and two more for a point
// that closes one; the back end's serialiser emits one byte per cycle unless out_stall holds it.
// A two-entry queue lets the front take points while the serialiser is busy.
// Reset is asynchronous and active low: it empties the queue and output register,
// restarts the frame and returns the registers to their reset values.
`default_nettype none

module modbus_rtu_point_framer_core #(
    parameter int MAX_POINTS = mrpf_pkg::MAX_POINTS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire mrpf_pkg::point_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output mrpf_pkg::frame_t      out_data,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [7:0]  slave_address_reg;
    logic [15:0] start_register_reg;
    logic [2:0]  points_per_frame_reg;
    logic        cfg_write;

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             head_valid;
    mrpf_pkg::entry_t push_entry;
    mrpf_pkg::entry_t head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg    <= mrpf_pkg::SLAVE_ADDRESS_RESET;
            start_register_reg   <= mrpf_pkg::START_REGISTER_RESET;
            points_per_frame_reg <= mrpf_pkg::POINTS_PER_FRAME_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                mrpf_pkg::REG_SLAVE_ADDRESS:    slave_address_reg    <= pwdata[7:0];
                mrpf_pkg::REG_START_REGISTER:   start_register_reg   <= pwdata[15:0];
                mrpf_pkg::REG_POINTS_PER_FRAME: points_per_frame_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            mrpf_pkg::REG_SLAVE_ADDRESS:    prdata = {24'd0, slave_address_reg};
            mrpf_pkg::REG_START_REGISTER:   prdata = {16'd0, start_register_reg};
            mrpf_pkg::REG_POINTS_PER_FRAME: prdata = {29'd0, points_per_frame_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    assign in_stall = queue_full;

    mrpf_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_data          (in_data),
        .queue_full       (queue_full),
        .slave_address    (slave_address_reg),
        .start_register   (start_register_reg),
        .points_per_frame (points_per_frame_reg),
        .push             (push),
        .entry            (push_entry)
    );

    mrpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    mrpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

/* rtl/mrpf_front.sv */
`default_nettype none

module mrpf_front #(
    parameter int MAX_POINTS = mrpf_pkg::MAX_POINTS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire mrpf_pkg::point_t in_data,
    input  wire logic             queue_full,
    input  wire logic [7:0]       slave_address,
    input  wire logic [15:0]      start_register,
    input  wire logic [2:0]       points_per_frame,
    output logic                  push,
    output mrpf_pkg::entry_t      entry
);

    localparam logic [2:0] MAX_N = 3'((MAX_POINTS > 7) ? 7 : MAX_POINTS);

    logic [2:0] point_index_reg, point_index_next;
    logic [2:0] n_eff;
    logic [3:0] index_inc;
    logic       last;

    always_comb
    begin
        n_eff = (points_per_frame == 3'd0) ? 3'd1 : points_per_frame;
        if (n_eff > MAX_N)
            n_eff = MAX_N;
    end

    assign index_inc = {1'b0, point_index_reg} + 4'd1;
    assign last      = (index_inc >= {1'b0, n_eff});
    assign push      = in_valid && !queue_full;

    always_comb
    begin
        entry.word_x     = mrpf_pkg::times_ten(in_data.pos_x);
        entry.word_y     = mrpf_pkg::times_ten(in_data.pos_y);
        entry.word_z     = mrpf_pkg::times_ten(in_data.pos_z);
        entry.word_a     = mrpf_pkg::times_ten(in_data.rot_angle);
        entry.speed      = in_data.move_speed;
        entry.valve      = in_data.valve_on;
        entry.first      = (point_index_reg == 3'd0);
        entry.last       = last;
        entry.slave      = slave_address;
        entry.start_reg  = start_register;
        // Five registers and ten bytes per point.
        entry.reg_count  = ({5'd0, n_eff} << 2) + {5'd0, n_eff};
        entry.byte_count = entry.reg_count << 1;
    end

    always_comb
    begin
        point_index_next = point_index_reg;
        if (push)
            point_index_next = last ? 3'd0 : index_inc[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_index_reg <= 3'd0;
        else
            point_index_reg <= point_index_next;
    end

endmodule

`default_nettype wire

/* rtl/mrpf_queue.sv */
`default_nettype none

module mrpf_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mrpf_pkg::entry_t push_entry,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output mrpf_pkg::entry_t      head
);

    localparam int DEPTH = mrpf_pkg::QUEUE_DEPTH;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mrpf_pkg::entry_t slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

/* rtl/mrpf_back.sv */
`default_nettype none

module mrpf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire mrpf_pkg::entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output mrpf_pkg::frame_t      out_data
);

    // Byte positions within the bytes one point produces.
    localparam logic [4:0] POS_SLAVE    = 5'd0;
    localparam logic [4:0] POS_FUNC     = 5'd1;
    localparam logic [4:0] POS_START_HI = 5'd2;
    localparam logic [4:0] POS_START_LO = 5'd3;
    localparam logic [4:0] POS_REGS_HI  = 5'd4;
    localparam logic [4:0] POS_REGS_LO  = 5'd5;
    localparam logic [4:0] POS_BYTES    = 5'd6;
    localparam logic [4:0] POS_X_HI     = 5'd7;
    localparam logic [4:0] POS_X_LO     = 5'd8;
    localparam logic [4:0] POS_Y_HI     = 5'd9;
    localparam logic [4:0] POS_Y_LO     = 5'd10;
    localparam logic [4:0] POS_Z_HI     = 5'd11;
    localparam logic [4:0] POS_Z_LO     = 5'd12;
    localparam logic [4:0] POS_A_HI     = 5'd13;
    localparam logic [4:0] POS_A_LO     = 5'd14;
    localparam logic [4:0] POS_SPEED    = 5'd15;
    localparam logic [4:0] POS_VALVE    = 5'd16;
    localparam logic [4:0] POS_CRC_LO   = 5'd17;
    localparam logic [4:0] POS_CRC_HI   = 5'd18;

    logic             started_reg, started_next;
    logic [4:0]       pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic             out_valid_reg, out_valid_next;
    mrpf_pkg::frame_t out_data_reg;

    logic [4:0]  pos;
    logic [7:0]  byte_sel;
    logic        load;
    logic        entry_done;
    logic [15:0] crc_base;

    // A point that does not open a frame skips the header positions.
    assign pos  = started_reg ? pos_reg : (head.first ? POS_SLAVE : POS_X_HI);
    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign entry_done = (pos == POS_CRC_HI) || (pos == POS_VALVE && !head.last);
    assign pop  = load && entry_done;

    always_comb
    begin
        case (pos)
            POS_SLAVE:    byte_sel = head.slave;
            POS_FUNC:     byte_sel = mrpf_pkg::FUNC_WRITE_MULTI;
            POS_START_HI: byte_sel = head.start_reg[15:8];
            POS_START_LO: byte_sel = head.start_reg[7:0];
            POS_REGS_HI:  byte_sel = 8'h00;
            POS_REGS_LO:  byte_sel = head.reg_count;
            POS_BYTES:    byte_sel = head.byte_count;
            POS_X_HI:     byte_sel = head.word_x[15:8];
            POS_X_LO:     byte_sel = head.word_x[7:0];
            POS_Y_HI:     byte_sel = head.word_y[15:8];
            POS_Y_LO:     byte_sel = head.word_y[7:0];
            POS_Z_HI:     byte_sel = head.word_z[15:8];
            POS_Z_LO:     byte_sel = head.word_z[7:0];
            POS_A_HI:     byte_sel = head.word_a[15:8];
            POS_A_LO:     byte_sel = head.word_a[7:0];
            POS_SPEED:    byte_sel = head.speed;
            POS_VALVE:    byte_sel = {7'd0, head.valve};
            POS_CRC_LO:   byte_sel = crc_reg[7:0];
            POS_CRC_HI:   byte_sel = crc_reg[15:8];
            default:      byte_sel = 8'h00;
        endcase
    end

    // The checksum restarts with the slave address of every frame.
    assign crc_base = (pos == POS_SLAVE) ? mrpf_pkg::CRC_INIT : crc_reg;

    always_comb
    begin
        started_next   = started_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            started_next   = !entry_done;
            pos_next       = pos + 5'd1;
            if (pos <= POS_VALVE)
                crc_next = mrpf_pkg::crc16_byte(crc_base, byte_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            pos_reg       <= POS_SLAVE;
            crc_reg       <= mrpf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.frame_byte <= byte_sel;
            out_data_reg.frame_end  <= (pos == POS_CRC_HI);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/mrpf_checker.sv */
`default_nettype none

module mrpf_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire mrpf_pkg::frame_t out_data,
    input wire logic             pready
);

    // Bytes delivered since the last closing checksum byte.
    logic [6:0] bytes_reg, bytes_next;
    logic       out_beat;

    assign out_beat = out_valid && !out_stall;

    always_comb
    begin
        bytes_next = bytes_reg;
        if (out_beat)
            bytes_next = out_data.frame_end ? 7'd0 : bytes_reg + 7'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bytes_reg <= 7'd0;
        else
            bytes_reg <= bytes_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // Shortest frame: header, one point and the checksum, nineteen bytes.
    a_frame_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && out_data.frame_end |-> bytes_reg >= 7'd18)
        else $error("frame closed too early");

    // Longest frame: header, seven points and the checksum, seventy-nine bytes.
    a_frame_max: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= 7'd78)
        else $error("frame ran on without a checksum");

endmodule

bind modbus_rtu_point_framer_core mrpf_checker u_mrpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pready    (pready)
);

`default_nettype wire
